@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication, clocked on clk, quiet during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent now, consequent on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mhpq_pkg.sv @@
// ---------------------------------------------------------------------------
// mhpq_pkg
// Item types and operation codes for the max-heap priority queue.
// ---------------------------------------------------------------------------
package mhpq_pkg;

  typedef logic signed [31:0] key_t;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef struct packed {
    logic op;
    key_t key;
  } in_item_t;

  typedef struct packed {
    key_t max_key;
    logic was_empty;
    logic dropped_full;
  } out_item_t;

endpackage

@@ src/mhpq_store.sv @@
// ---------------------------------------------------------------------------
// mhpq_store
// Heap key store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module mhpq_store #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  mhpq_pkg::key_t             wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr0,
  input  logic [$clog2(DEPTH)-1:0]   raddr1,
  output mhpq_pkg::key_t             rdata0,
  output mhpq_pkg::key_t             rdata1
);
  import mhpq_pkg::*;

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ src/max_heap_priority_queue.sv @@
// ---------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit keys held in a synchronous RAM.
// ---------------------------------------------------------------------------
//
//  channel | signals                   | payload     | direction
//  --------+---------------------------+-------------+----------
//  in      | in_valid / in_ready       | in_item_t   | into block
//  out     | out_valid / out_ready     | out_item_t  | out of block
//
//  One item at a time. Each heap level takes a RAM read state and a
//  compare/write state: an insert rises through S_UP_RD and S_UP_CMP, an
//  extract loads root and tail in S_DN_LOAD and sinks through S_DN_RD and
//  S_DN_CMP. Reset clears count and control; data from slots past count is
//  never used. A held result stalls only an item that makes a new one, which
//  waits in S_OUT with in_ready low.
//
module max_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mhpq_pkg::out_item_t out_item
);
  import mhpq_pkg::*;

  // count holds 0..CAPACITY; child can reach twice a slot index
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LOAD = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  // control registers
  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] slot, slot_next;     // insert hole / extract parent
  logic [CW:0]   child, child_next;   // left child of slot during sift-down
  // payload registers
  key_t          key_r, key_r_next;   // key being inserted
  key_t          top, top_next;       // removed root
  key_t          last, last_next;     // element moved from the tail
  out_item_t     res, res_next;       // result waiting for the output stage
  out_item_t     out_item_next;
  logic          out_valid_next;

  // RAM port controls
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr0, mem_raddr1;
  key_t          mem_wdata, mem_rdata0, mem_rdata1;

  // sift-down selection
  logic [CW-1:0] child_s, child_s1, pick_slot;
  key_t          pick_key;
  logic          take_right;

  // accepted insert that has room
  logic          ins_grow;

  // one-based slot to zero-based RAM address
  function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] s);
    logic [CW-1:0] z;
    z = s - CW'(1);
    return z[AW-1:0];
  endfunction

  mhpq_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

  assign in_ready = (state == S_IDLE);

  assign ins_grow = in_valid && in_ready && (in_item.op == OP_INSERT) &&
                    (count != CW'(CAPACITY));

  // child is within 1..count whenever it indexes the RAM
  assign child_s    = child[CW-1:0];
  assign child_s1   = child_s + CW'(1);
  assign take_right = (child_s < count) && (mem_rdata1 > mem_rdata0);
  assign pick_slot  = take_right ? child_s1 : child_s;
  assign pick_key   = take_right ? mem_rdata1 : mem_rdata0;

  always_comb begin
    state_next     = state;
    count_next     = count;
    slot_next      = slot;
    child_next     = child;
    key_r_next     = key_r;
    top_next       = top;
    last_next      = last;
    res_next       = res;
    out_item_next  = out_item;
    out_valid_next = out_valid && !out_ready;

    mem_we     = 1'b0;
    mem_waddr  = slot_addr(slot);
    mem_wdata  = key_r;
    mem_raddr0 = slot_addr(CW'(1));
    mem_raddr1 = slot_addr(count);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.op == OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              res_next   = '{max_key: '0, was_empty: 1'b0, dropped_full: 1'b1};
              state_next = S_OUT;
            end else begin
              count_next = count + CW'(1);
              slot_next  = count + CW'(1);
              key_r_next = in_item.key;
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              res_next   = '{max_key: '0, was_empty: 1'b1, dropped_full: 1'b0};
              state_next = S_OUT;
            end else begin
              // root and tail reads issued now, data in S_DN_LOAD
              state_next = S_DN_LOAD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (slot == CW'(1)) begin
          mem_we     = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem_raddr0 = slot_addr(slot >> 1);
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (key_r > mem_rdata0) begin
          // parent moves down into the hole
          mem_wdata  = mem_rdata0;
          slot_next  = slot >> 1;
          state_next = S_UP_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DN_LOAD: begin
        top_next   = mem_rdata0;
        last_next  = mem_rdata1;
        count_next = count - CW'(1);
        slot_next  = CW'(1);
        child_next = (CW+1)'(2);
        state_next = S_DN_RD;
      end
      S_DN_RD: begin
        if (child > {1'b0, count}) begin
          mem_we     = 1'b1;
          mem_wdata  = last;
          res_next   = '{max_key: top, was_empty: 1'b0, dropped_full: 1'b0};
          state_next = S_OUT;
        end else begin
          mem_raddr0 = slot_addr(child_s);
          mem_raddr1 = (child_s < count) ? slot_addr(child_s1) : slot_addr(child_s);
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (pick_key > last) begin
          mem_wdata  = pick_key;
          slot_next  = pick_slot;
          child_next = {pick_slot, 1'b0};
          state_next = S_DN_RD;
        end else begin
          mem_wdata  = last;
          res_next   = '{max_key: top, was_empty: 1'b0, dropped_full: 1'b0};
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_item_next  = res;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    slot     <= slot_next;
    child    <= child_next;
    key_r    <= key_r_next;
    top      <= top_next;
    last     <= last_next;
    res      <= res_next;
    out_item <= out_item_next;
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY), "element count above capacity")
  `ASSERT_ALWAYS(a_idle_no_write, (state != S_IDLE) || !mem_we, "RAM write while idle")
  `ASSERT_ALWAYS(a_child_in_range, (state != S_DN_CMP) || (child <= {1'b0, count}), "child past tail")
  `ASSERT_NEXT(a_insert_grows, ins_grow, count == $past(count) + CW'(1), "count did not grow")

endmodule

@@ verif/max_heap_priority_queue_checker.sv @@
// ---------------------------------------------------------------------------
// max_heap_priority_queue_checker
// Watches both channels of the heap, keeps its own copy of the heap, predicts
// the result of every accepted item that makes one and compares it with what comes out.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module max_heap_priority_queue_checker #(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mhpq_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mhpq_pkg::out_item_t out_item,
  output int                  errors,
  output int                  outstanding,
  output int                  results_seen,
  output int                  empties_seen,
  output int                  drops_seen,
  output int                  peak_size
);

  import mhpq_pkg::*;

  key_t      heap_keys [1:CAPACITY];
  int        fill_count;
  out_item_t pending_results [$];

  initial begin
    errors       = 0;
    outstanding  = 0;
    results_seen = 0;
    empties_seen = 0;
    drops_seen   = 0;
    peak_size    = 0;
    fill_count   = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Apply one accepted item to the shadow heap, queue the result it causes.
  task automatic heap_apply(input in_item_t item);
    key_t k;
    key_t top_key;
    key_t last_key;
    int   slot;
    int   child;
    k = item.key;
    if (item.op == OP_INSERT) begin
      if (fill_count >= CAPACITY) begin
        pending_results.push_back(out_item_t'{max_key: '0, was_empty: 1'b0,
                                              dropped_full: 1'b1});
      end else begin
        fill_count++;
        slot = fill_count;
        // rise only past a strictly smaller parent
        while (slot != 1 && k > heap_keys[slot / 2]) begin
          heap_keys[slot] = heap_keys[slot / 2];
          slot = slot / 2;
        end
        heap_keys[slot] = k;
        if (fill_count > peak_size) peak_size = fill_count;
      end
    end else if (fill_count == 0) begin
      pending_results.push_back(out_item_t'{max_key: '0, was_empty: 1'b1,
                                            dropped_full: 1'b0});
    end else begin
      top_key  = heap_keys[1];
      last_key = heap_keys[fill_count];
      fill_count--;
      slot  = 1;
      child = 2;
      while (child <= fill_count) begin
        // right child only when strictly larger; ties go left
        if (child < fill_count && heap_keys[child + 1] > heap_keys[child]) child++;
        if (!(heap_keys[child] > last_key)) break;
        heap_keys[slot] = heap_keys[child];
        slot  = child;
        child = child * 2;
      end
      heap_keys[slot] = last_key;
      pending_results.push_back(out_item_t'{max_key: top_key, was_empty: 1'b0,
                                            dropped_full: 1'b0});
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item waiting, max_key", out_item.max_key, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_item.max_key !== want.max_key)
            report_mismatch("max_key", out_item.max_key, want.max_key);
          if (out_item.was_empty !== want.was_empty)
            report_mismatch("was_empty", out_item.was_empty, want.was_empty);
          if (out_item.dropped_full !== want.dropped_full)
            report_mismatch("dropped_full", out_item.dropped_full, want.dropped_full);
          if (want.was_empty) empties_seen++;
          if (want.dropped_full) drops_seen++;
        end
      end
      if (in_valid && in_ready) heap_apply(in_item);
      outstanding = pending_results.size();
    end
  end

endmodule

@@ verif/max_heap_priority_queue_tb.sv @@
// ---------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Drives inserts and extracts into the heap with random gaps and output
// stalls; a checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module max_heap_priority_queue_tb;

  import mhpq_pkg::*;

  localparam int CAPACITY    = 1024;
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int HOLD_OFF    = 400;   // long receiver stall, fills the block up
  localparam int DRAIN_WAIT  = 64;    // settle time after the last result
  localparam int RANDOM_ITEMS = 775;
  localparam int CALM_ITEMS   = 150;  // tail of the random part with no idling

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  logic calm         = 1'b0;  // no idling on either side
  logic pressure_req = 1'b0;  // ask the receiver for its long stall

  int errors;
  int outstanding;
  int results_seen;
  int empties_seen;
  int drops_seen;
  int peak_size;
  int items_sent   = 0;
  int stall_cycles = 0;

  // insert share per chunk of 100 random items: heap grows, shrinks, grows
  int mix_pct [8] = '{70, 85, 60, 40, 75, 50, 25, 55};

  max_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  max_heap_priority_queue_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .errors      (errors),
    .outstanding (outstanding),
    .results_seen(results_seen),
    .empties_seen(empties_seen),
    .drops_seen  (drops_seen),
    .peak_size   (peak_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles, %0d results still due",
             STALL_LIMIT, outstanding);
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // output register fills, the block stops and in_ready drops while the
  // sender keeps offering items.
  initial begin
    int  hold;
    bit  pressure_done;
    hold = 0;
    pressure_done = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (pressure_req && !pressure_done) begin
        pressure_done = 1;
        hold = HOLD_OFF - 1;
        out_ready <= 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Keys lean on the extremes and on a narrow band so equal keys are common.
  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 9))
      0:       k = 32'sh7FFF_FFFF;
      1:       k = 32'sh8000_0000;
      2, 3, 4: k = $signed($urandom_range(0, 7)) - 32'sd3;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Offer one item; returns at the edge where it is taken. Valid stays high
  // straight into the next item unless a gap is drawn.
  task automatic send_item(input logic item_op, input key_t item_key);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= in_item_t'{op: item_op, key: item_key};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  initial begin
    logic op;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed ----
    // extract from an empty heap, then the key extremes in and out
    send_item(OP_EXTRACT, 32'sd0);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_EXTRACT, 32'sh7FFF_FFFF);
    send_item(OP_EXTRACT, 32'sh8000_0000);
    // equal keys: no rise past an equal parent, ties between children go left
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_INSERT, 32'sd7);
    send_item(OP_INSERT, 32'sd7);
    send_item(OP_INSERT, 32'sd3);
    send_item(OP_EXTRACT, -32'sd1);
    send_item(OP_EXTRACT, 32'sd0);
    send_item(OP_EXTRACT, 32'sd0);
    // drain what is left and run past empty twice
    repeat (8) send_item(OP_EXTRACT, $urandom);

    // ---- random mix, chunked insert share, long receiver stall midway ----
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) pressure_req <= 1'b1;
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      op = ($urandom_range(0, 99) < mix_pct[(i / 100) % 8]) ? OP_INSERT : OP_EXTRACT;
      send_item(op, pick_key());
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d items through the heap: %0d results checked, peak fill %0d of %0d.",
             items_sent, results_seen, peak_size, CAPACITY);
    $display("Seen %0d extracts on an empty heap and %0d inserts refused when full.",
             empties_seen, drops_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
